[design/ace_pkg.sv]
package ace_pkg;

  localparam int SCREEN_ROWS_DEF = 96;
  localparam int WRAP_COLUMN_DEF = 256;
  localparam int QUEUE_DEPTH_DEF = 2;

  // byte slots of one cell, in stream order
  localparam int SGR_LEN  = 14;
  localparam int CUR_LEN  = 10;
  localparam int WRAP_LEN = 5;
  localparam int HOME_LEN = 6;
  localparam int NPOS     = 2 * SGR_LEN + CUR_LEN + WRAP_LEN + 1 + HOME_LEN;
  localparam int POS_W    = $clog2(NPOS);

  localparam logic [POS_W-1:0] P_CUR  = POS_W'(SGR_LEN);
  localparam logic [POS_W-1:0] P_WRAP = POS_W'(SGR_LEN + CUR_LEN);
  localparam logic [POS_W-1:0] P_MIN  = POS_W'(SGR_LEN + CUR_LEN + WRAP_LEN);
  localparam logic [POS_W-1:0] P_CHAR = POS_W'(2 * SGR_LEN + CUR_LEN + WRAP_LEN);
  localparam logic [POS_W-1:0] P_HOME = POS_W'(2 * SGR_LEN + CUR_LEN + WRAP_LEN + 1);

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_FOUR  = 8'h34;
  localparam logic [7:0] CH_FIVE  = 8'h35;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_LB    = 8'h5B;
  localparam logic [7:0] CH_M     = 8'h6D;

  typedef struct packed {
    logic [3:0] hun;
    logic [3:0] ten;
    logic [3:0] one;
  } dec3_t;

  typedef struct packed {
    logic [NPOS-1:0] mask;
    logic [7:0]      attr;
    logic [7:0]      chr;
    dec3_t           row_dec;
    dec3_t           col_dec;
  } cmd_t;

  // value is at most 256
  function automatic dec3_t to_dec3(input logic [8:0] v);
    logic [7:0]  r;
    logic [15:0] p;
    logic [3:0]  t;
    dec3_t       d;
    d.hun = '0;
    if (v >= 9'd200) begin
      d.hun = 4'd2;
      r = 8'(v - 9'd200);
    end else if (v >= 9'd100) begin
      d.hun = 4'd1;
      r = 8'(v - 9'd100);
    end else begin
      r = v[7:0];
    end
    // r * 103 / 1024 is exact division by ten below 100
    p = {8'b0, r} * 16'd103;
    t = p[13:10];
    d.ten = t;
    d.one = 4'(r - 8'({4'b0, t} * 8'd10));
    return d;
  endfunction

  // p: faint, blink, fg, bg present
  function automatic logic [SGR_LEN-1:0] sgr_mask(input logic [7:0] na, input logic [3:0] p);
    logic [SGR_LEN-1:0] m;
    m[0]  = 1'b1;
    m[1]  = 1'b1;
    m[2]  = p[3] & ~na[7];
    m[3]  = p[3];
    m[4]  = p[2] & p[3];
    m[5]  = p[2] & ~na[6];
    m[6]  = p[2];
    m[7]  = p[1] & (p[3] | p[2]);
    m[8]  = p[1];
    m[9]  = p[1];
    m[10] = p[0] & (|p[3:1]);
    m[11] = p[0];
    m[12] = p[0];
    m[13] = 1'b1;
    return m;
  endfunction

  function automatic logic [7:0] digit(input logic [3:0] d);
    return CH_ZERO + {4'b0, d};
  endfunction

  function automatic logic [7:0] sgr_byte(input logic [3:0] k, input logic [7:0] na);
    logic [7:0] b;
    unique case (k)
      4'd0:    b = CH_ESC;
      4'd1:    b = CH_LB;
      4'd2:    b = CH_TWO;
      4'd3:    b = CH_TWO;
      4'd4:    b = CH_SEMI;
      4'd5:    b = CH_TWO;
      4'd6:    b = CH_FIVE;
      4'd7:    b = CH_SEMI;
      4'd8:    b = CH_THREE;
      4'd9:    b = digit({1'b0, na[5:3]});
      4'd10:   b = CH_SEMI;
      4'd11:   b = CH_FOUR;
      4'd12:   b = digit({1'b0, na[2:0]});
      default: b = CH_M;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] cmd_byte(input logic [POS_W-1:0] pos, input cmd_t c);
    logic [7:0]       b;
    logic [POS_W-1:0] k;
    b = CH_ESC;
    k = '0;
    priority if (pos < P_CUR) begin
      b = sgr_byte(4'(pos), c.attr);
    end else if (pos < P_WRAP) begin
      k = pos - P_CUR;
      unique case (k)
        POS_W'(0): b = CH_ESC;
        POS_W'(1): b = CH_LB;
        POS_W'(2): b = digit(c.row_dec.hun);
        POS_W'(3): b = digit(c.row_dec.ten);
        POS_W'(4): b = digit(c.row_dec.one);
        POS_W'(5): b = CH_SEMI;
        POS_W'(6): b = digit(c.col_dec.hun);
        POS_W'(7): b = digit(c.col_dec.ten);
        POS_W'(8): b = digit(c.col_dec.one);
        default:   b = CH_H;
      endcase
    end else if (pos < P_MIN) begin
      k = pos - P_WRAP;
      unique case (k)
        POS_W'(0): b = CH_NL;
        POS_W'(1): b = CH_ESC;
        POS_W'(2): b = CH_LB;
        POS_W'(3): b = CH_ONE;
        default:   b = CH_A;
      endcase
    end else if (pos < P_CHAR) begin
      b = sgr_byte(4'(pos - P_MIN), c.attr);
    end else if (pos < P_HOME) begin
      b = c.chr;
    end else begin
      k = pos - P_HOME;
      unique case (k)
        POS_W'(0): b = CH_ESC;
        POS_W'(1): b = CH_LB;
        POS_W'(2): b = CH_ONE;
        POS_W'(3): b = CH_SEMI;
        POS_W'(4): b = CH_ONE;
        default:   b = CH_H;
      endcase
    end
    return b;
  endfunction

endpackage

[design/ace_if.sv]
interface ace_in_if;
  logic              valid;
  logic              ready;
  logic [15:0]       cell_word;
  logic signed [8:0] screen_row;
  logic [7:0]        image_column;
  logic [7:0]        column_offset;
  logic              first_in_image;
  logic              first_in_row;
  logic              last_in_image;

  modport source (
    output valid, cell_word, screen_row, image_column, column_offset,
           first_in_image, first_in_row, last_in_image,
    input  ready
  );
  modport sink (
    input  valid, cell_word, screen_row, image_column, column_offset,
           first_in_image, first_in_row, last_in_image,
    output ready
  );
endinterface

interface ace_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink (input valid, out_byte, last_byte, output ready);
endinterface

[design/ansi_attribute_cell_encoder.sv]
// Turns character cells into an ANSI terminal byte stream, one byte per result. The input
// side takes one cell per cycle while the command queue (QUEUE_DEPTH entries) has room; a
// cell that causes no byte is dropped at the input. While the receiver is ready, the output
// side sends one byte per cycle and plain characters stream at one cell per cycle; a cell
// causing n bytes (1 for a plain character, up to 35 with attribute, cursor, wrap and home
// sequences at the default row count) holds the byte sequencer until all n are sent.
// last_byte marks the final byte of each cell. Rows outside 0..SCREEN_ROWS-1 emit only the
// full SGR of a first cell and the home sequence of a last cell.
module ansi_attribute_cell_encoder #(
  parameter int SCREEN_ROWS = ace_pkg::SCREEN_ROWS_DEF,
  parameter int WRAP_COLUMN = ace_pkg::WRAP_COLUMN_DEF,
  parameter int QUEUE_DEPTH = ace_pkg::QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ace_in_if.sink    in_ch,
  ace_out_if.source out_ch
);
  import ace_pkg::*;

  cmd_t front_cmd, head;
  logic front_valid, front_ready, head_valid, pop;

  ace_front #(
    .SCREEN_ROWS (SCREEN_ROWS),
    .WRAP_COLUMN (WRAP_COLUMN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd       (front_cmd),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready)
  );

  ace_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_data  (front_cmd),
    .push       (front_valid),
    .push_ready (front_ready),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  ace_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

[design/ace_front.sv]
module ace_front #(
  parameter int SCREEN_ROWS = ace_pkg::SCREEN_ROWS_DEF,
  parameter int WRAP_COLUMN = ace_pkg::WRAP_COLUMN_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  ace_in_if.sink        in_ch,
  output ace_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_ready
);
  import ace_pkg::*;

  logic [7:0]          attr_r, attr_nxt;
  logic [7:0]          na, ca, diff;
  logic                vis, nl, wrap, do_min, accept;
  logic [9:0]          row_u;
  logic [8:0]          rowp1, colp1, xcol;
  logic [SGR_LEN-1:0]  full_m, min_m;
  logic [CUR_LEN-1:0]  cur_m;
  logic [WRAP_LEN-1:0] wrap_m;
  logic [HOME_LEN-1:0] home_m;

  always_comb begin
    na    = in_ch.cell_word[15:8];
    row_u = {2'b0, in_ch.screen_row[7:0]};
    vis   = !in_ch.screen_row[8] && (row_u < 10'(SCREEN_ROWS));
    nl    = (row_u + 10'd1) < 10'(SCREEN_ROWS);
    rowp1 = {1'b0, in_ch.screen_row[7:0]} + 9'd1;
    colp1 = {1'b0, in_ch.image_column} + 9'd1;
    xcol  = {1'b0, in_ch.image_column} + {1'b0, in_ch.column_offset};
    wrap  = vis && (xcol == 9'(WRAP_COLUMN));

    // a first cell loads the attributes before the change check
    ca     = in_ch.first_in_image ? na : attr_r;
    diff   = ca ^ na;
    do_min = vis && (diff != 8'd0);

    full_m = in_ch.first_in_image ? sgr_mask(na, 4'hF) : '0;
    min_m  = do_min ? sgr_mask(na, {diff[7], diff[6], |diff[5:3], |diff[2:0]}) : '0;

    cur_m = '0;
    if (vis && in_ch.first_in_row) begin
      cur_m = {1'b1, 1'b1, colp1 >= 9'd10, colp1 >= 9'd100, 1'b1,
               1'b1, rowp1 >= 9'd10, rowp1 >= 9'd100, 1'b1, 1'b1};
    end
    wrap_m = wrap ? {4'hF, nl} : '0;
    home_m = in_ch.last_in_image ? '1 : '0;

    cmd.mask    = {home_m, vis, min_m, wrap_m, cur_m, full_m};
    cmd.attr    = na;
    cmd.chr     = in_ch.cell_word[7:0];
    cmd.row_dec = to_dec3(rowp1);
    cmd.col_dec = to_dec3(colp1);
  end

  // cells with no bytes are dropped here
  assign cmd_valid   = in_ch.valid && (|cmd.mask);
  assign in_ch.ready = cmd_ready;
  assign accept      = in_ch.valid && cmd_ready;

  always_comb begin
    attr_nxt = attr_r;
    if (accept && (in_ch.first_in_image || vis)) begin
      attr_nxt = na;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= '0;
    end else begin
      attr_r <= attr_nxt;
    end
  end

endmodule

[design/ace_queue.sv]
module ace_queue #(
  parameter int DEPTH = ace_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ace_pkg::cmd_t push_data,
  input  logic          push,
  output logic          push_ready,
  output ace_pkg::cmd_t head,
  output logic          head_valid,
  input  logic          pop
);
  import ace_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign head_valid = count_r != '0;
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[design/ace_back.sv]
module ace_back (
  input  logic          clk,
  input  logic          rst_n,
  input  ace_pkg::cmd_t head,
  input  logic          head_valid,
  output logic          pop,
  ace_out_if.source     out_ch
);
  import ace_pkg::*;

  logic [NPOS-1:0] done_r, done_nxt;
  logic [NPOS-1:0] rem, sel;
  logic            last, take;
  logic [7:0]      b;

  // lowest slot of the head request not yet sent
  assign rem  = head.mask & ~done_r;
  assign sel  = rem & (~rem + NPOS'(1));
  assign last = (rem & ~sel) == '0;
  assign take = head_valid && out_ch.ready;
  assign pop  = take && last;

  always_comb begin
    b = '0;
    for (int i = 0; i < NPOS; i++) begin
      if (sel[i]) begin
        b = b | cmd_byte(POS_W'(i), head);
      end
    end
  end

  assign out_ch.valid     = head_valid;
  assign out_ch.out_byte  = b;
  assign out_ch.last_byte = last;

  always_comb begin
    done_nxt = done_r;
    if (take) begin
      done_nxt = last ? '0 : (done_r | sel);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
    end else begin
      done_r <= done_nxt;
    end
  end

endmodule

[design/ace_checker.sv]
module ace_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last_byte
);

  // input stalls only behind a full queue, which always has bytes to send
  a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |-> out_valid)
    else $error("input stalled with no output pending");

  // output goes quiet only after the final byte of a cell
  a_drain_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(out_valid && out_ready && last_byte))
    else $error("output dropped in the middle of a cell");

  a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("output valid right after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid withdrawn while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(last_byte))
    else $error("output payload changed while stalled");

endmodule

bind ansi_attribute_cell_encoder ace_checker u_ace_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .last_byte (out_ch.last_byte)
);

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int ROWS_VISIBLE = 96;
  localparam int WRAP_COL     = 256;
  localparam int CELL_TARGET  = 310;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 40;

  localparam logic [7:0] B_NL   = 8'h0A;
  localparam logic [7:0] B_ESC  = 8'h1B;
  localparam logic [7:0] B_ZERO = 8'h30;
  localparam logic [7:0] B_ONE  = 8'h31;
  localparam logic [7:0] B_SEMI = 8'h3B;
  localparam logic [7:0] B_UP   = 8'h41;
  localparam logic [7:0] B_POS  = 8'h48;
  localparam logic [7:0] B_LB   = 8'h5B;
  localparam logic [7:0] B_SGR  = 8'h6D;

  typedef struct {
    logic [15:0]       word;
    logic signed [8:0] row;
    logic [7:0]        icol;
    logic [7:0]        coff;
    logic              fimg;
    logic              frow;
    logic              limg;
  } cell_req_t;

  typedef struct {
    logic [7:0] ch;
    logic       is_last;
  } term_byte_t;

  logic clk;
  logic rst_n;

  ace_in_if  in_if ();
  ace_out_if out_if ();

  ansi_attribute_cell_encoder #(
    .SCREEN_ROWS(ROWS_VISIBLE),
    .WRAP_COLUMN(WRAP_COL)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  term_byte_t expected_bytes[$];
  logic [7:0] cell_bytes[$];
  logic [7:0] shadow_attr;

  int errors;
  int cycle_count;
  int cells_sent;
  int bytes_checked;
  int wrap_count;
  int restyle_count;
  int hidden_count;
  int burst_left;
  bit steady_send;

  int stall_mode;
  int stall_mode_left;
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void put_dec(int v);
    if (v >= 100) cell_bytes.push_back(8'(B_ZERO + (v / 100)));
    if (v >= 10) cell_bytes.push_back(8'(B_ZERO + ((v / 10) % 10)));
    cell_bytes.push_back(8'(B_ZERO + (v % 10)));
  endfunction

  function automatic void put_code(int v, inout bit sep);
    if (sep) cell_bytes.push_back(B_SEMI);
    put_dec(v);
    sep = 1'b1;
  endfunction

  // bytes one cell puts on the terminal stream, and the attribute update
  function automatic void encode_cell(cell_req_t c);
    logic [7:0] na;
    logic [7:0] diff;
    int         r;
    int         x;
    bit         sep;
    na = c.word[15:8];
    r = int'(c.row);
    x = int'(c.icol) + int'(c.coff);
    cell_bytes.delete();
    if (c.fimg) begin
      shadow_attr = na;
      cell_bytes.push_back(B_ESC);
      cell_bytes.push_back(B_LB);
      sep = 1'b0;
      put_code(na[7] ? 2 : 22, sep);
      put_code(na[6] ? 5 : 25, sep);
      put_code(30 + na[5:3], sep);
      put_code(40 + na[2:0], sep);
      cell_bytes.push_back(B_SGR);
    end
    if (r >= 0 && r < ROWS_VISIBLE) begin
      if (c.frow) begin
        cell_bytes.push_back(B_ESC);
        cell_bytes.push_back(B_LB);
        put_dec(r + 1);
        cell_bytes.push_back(B_SEMI);
        put_dec(int'(c.icol) + 1);
        cell_bytes.push_back(B_POS);
      end
      if (x == WRAP_COL) begin
        // no newline on the bottom row
        if (r < ROWS_VISIBLE - 1) cell_bytes.push_back(B_NL);
        cell_bytes.push_back(B_ESC);
        cell_bytes.push_back(B_LB);
        cell_bytes.push_back(B_ONE);
        cell_bytes.push_back(B_UP);
        wrap_count++;
      end
      if (shadow_attr != na) begin
        diff = shadow_attr ^ na;
        cell_bytes.push_back(B_ESC);
        cell_bytes.push_back(B_LB);
        sep = 1'b0;
        if (diff[7]) put_code(na[7] ? 2 : 22, sep);
        if (diff[6]) put_code(na[6] ? 5 : 25, sep);
        if (|diff[5:3]) put_code(30 + na[5:3], sep);
        if (|diff[2:0]) put_code(40 + na[2:0], sep);
        cell_bytes.push_back(B_SGR);
        shadow_attr = na;
        restyle_count++;
      end
      cell_bytes.push_back(c.word[7:0]);
    end else begin
      hidden_count++;
    end
    if (c.limg) begin
      cell_bytes.push_back(B_ESC);
      cell_bytes.push_back(B_LB);
      cell_bytes.push_back(B_ONE);
      cell_bytes.push_back(B_SEMI);
      cell_bytes.push_back(B_ONE);
      cell_bytes.push_back(B_POS);
    end
    foreach (cell_bytes[i])
      expected_bytes.push_back('{cell_bytes[i], i == cell_bytes.size() - 1});
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= 40) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // predict on each accepted request, then check each accepted byte
  always @(posedge clk) begin : stream_monitor
    cell_req_t  c;
    term_byte_t want;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        c.word = in_if.cell_word;
        c.row  = in_if.screen_row;
        c.icol = in_if.image_column;
        c.coff = in_if.column_offset;
        c.fimg = in_if.first_in_image;
        c.frow = in_if.first_in_row;
        c.limg = in_if.last_in_image;
        encode_cell(c);
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %h", out_if.out_byte));
        end else begin
          want = expected_bytes.pop_front();
          if (out_if.out_byte !== want.ch)
            report_mismatch($sformatf("byte %0d: out_byte %h, expected %h",
                                      bytes_checked, out_if.out_byte, want.ch));
          if (out_if.last_byte !== want.is_last)
            report_mismatch($sformatf("byte %0d: last_byte %b, expected %b",
                                      bytes_checked, out_if.last_byte, want.is_last));
        end
        bytes_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still expected",
               cycle_count, expected_bytes.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: always ready, light random stalls, or longer holds
  always @(negedge clk) begin
    if (stall_mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_mode_left = $urandom_range(20, 80);
    end else begin
      stall_mode_left--;
    end
    case (stall_mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (hold_left > 0) begin
          hold_left--;
          out_if.ready <= 1'b0;
        end else begin
          out_if.ready <= 1'b1;
          hold_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
        end
      end
    endcase
  end

  function automatic cell_req_t cell_of(logic [15:0] w, int row, int icol, int coff,
                                        bit fi, bit fr, bit li);
    cell_req_t c;
    c.word = w;
    c.row  = 9'(row);
    c.icol = 8'(icol);
    c.coff = 8'(coff);
    c.fimg = fi;
    c.frow = fr;
    c.limg = li;
    return c;
  endfunction

  task automatic send_cell(cell_req_t c);
    int gap;
    in_if.valid          <= 1'b1;
    in_if.cell_word      <= c.word;
    in_if.screen_row     <= c.row;
    in_if.image_column   <= c.icol;
    in_if.column_offset  <= c.coff;
    in_if.first_in_image <= c.fimg;
    in_if.first_in_row   <= c.frow;
    in_if.last_in_image  <= c.limg;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    cells_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else if (!steady_send) begin
      burst_left = $urandom_range(0, 15);
      gap = $urandom_range(1, 5);
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic test_full_sgr_and_cursor();
    // all attributes clear, top-left corner, null character
    send_cell(cell_of(16'h0000, 0, 0, 0, 1, 1, 0));
    // all attributes set, bottom row, last column
    send_cell(cell_of(16'hFFFF, 95, 255, 0, 1, 1, 1));
    send_cell(cell_of(16'hFF20, 9, 9, 0, 0, 1, 0));
    send_cell(cell_of(16'hFF7E, 98, 0, 0, 0, 1, 0));
  endtask

  task automatic test_column_wrap();
    send_cell(cell_of(16'hFF41, 0, 200, 56, 0, 0, 0));
    send_cell(cell_of(16'hFF42, 95, 255, 1, 0, 0, 0));
    send_cell(cell_of(16'hFF43, 94, 128, 128, 0, 1, 0));
    // just past and just before the wrap column
    send_cell(cell_of(16'hFF44, 3, 255, 2, 0, 0, 0));
    send_cell(cell_of(16'hFF45, 3, 255, 0, 0, 0, 0));
  endtask

  task automatic test_attribute_changes();
    send_cell(cell_of(16'h7F41, 5, 10, 1, 0, 0, 0));
    send_cell(cell_of(16'h3F42, 5, 10, 2, 0, 0, 0));
    send_cell(cell_of(16'h0742, 5, 10, 3, 0, 0, 0));
    send_cell(cell_of(16'h0042, 5, 10, 4, 0, 0, 0));
    send_cell(cell_of(16'hFF43, 5, 10, 5, 0, 0, 0));
    send_cell(cell_of(16'hC043, 5, 10, 6, 0, 0, 0));
  endtask

  task automatic test_hidden_rows();
    send_cell(cell_of(16'h0000, -1, 0, 0, 0, 1, 0));
    send_cell(cell_of(16'h1234, 96, 50, 206, 1, 1, 0));
    send_cell(cell_of(16'h5678, -256, 0, 0, 0, 0, 1));
    send_cell(cell_of(16'hAB00, 255, 255, 1, 0, 1, 0));
    // attributes loaded by the hidden first cell hold
    send_cell(cell_of(16'h1241, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_home_sequence();
    send_cell(cell_of(16'h1200, 10, 99, 3, 0, 1, 1));
    send_cell(cell_of(16'h125A, 40, 7, 1, 0, 0, 1));
  endtask

  // mostly well-formed images with random content, plus noise and broken flags
  task automatic test_random_images(int target, int steady_until);
    int                nrows;
    int                ncols;
    int                nnoise;
    logic [7:0]        attr;
    logic [7:0]        icol;
    logic signed [8:0] row0;
    cell_req_t         c;
    while (cells_sent < target) begin
      steady_send = (cells_sent < steady_until);
      if ($urandom_range(0, 4) == 0) begin
        nnoise = $urandom_range(1, 3);
        repeat (nnoise) begin
          c.word = 16'($urandom);
          c.row  = 9'($urandom);
          c.icol = 8'($urandom);
          c.coff = 8'($urandom);
          c.fimg = 1'($urandom);
          c.frow = 1'($urandom);
          c.limg = 1'($urandom);
          send_cell(c);
        end
      end else begin
        nrows = $urandom_range(1, 3);
        ncols = $urandom_range(1, 6);
        attr = 8'($urandom);
        icol = 8'($urandom);
        if (ncols > 1 && $urandom_range(0, 2) == 0)
          icol = 8'(WRAP_COL - $urandom_range(1, ncols - 1));
        case ($urandom_range(0, 7))
          0: row0 = 9'(ROWS_VISIBLE - 1 - $urandom_range(0, 1));
          1: row0 = 9'(ROWS_VISIBLE - 2 + $urandom_range(0, 3));
          2: row0 = 9'(-int'($urandom_range(1, 3)));
          default: row0 = 9'($urandom_range(0, ROWS_VISIBLE - 1));
        endcase
        for (int r = 0; r < nrows; r++) begin
          for (int col = 0; col < ncols; col++) begin
            if ($urandom_range(0, 3) == 0) begin
              if ($urandom_range(0, 1) == 0) attr ^= 8'(1 << $urandom_range(0, 7));
              else attr = 8'($urandom);
            end
            c.word = {attr, 8'($urandom)};
            c.row  = 9'(row0 + r);
            c.icol = icol;
            c.coff = 8'(col);
            c.fimg = (r == 0 && col == 0);
            c.frow = (col == 0);
            c.limg = (r == nrows - 1 && col == ncols - 1);
            if ($urandom_range(0, 11) == 0) begin
              case ($urandom_range(0, 2))
                0: c.fimg = ~c.fimg;
                1: c.frow = ~c.frow;
                default: c.limg = ~c.limg;
              endcase
            end
            send_cell(c);
          end
        end
      end
    end
    steady_send = 1'b0;
  endtask

  initial begin
    rst_n                = 1'b0;
    in_if.valid          = 1'b0;
    in_if.cell_word      = '0;
    in_if.screen_row     = '0;
    in_if.image_column   = '0;
    in_if.column_offset  = '0;
    in_if.first_in_image = 1'b0;
    in_if.first_in_row   = 1'b0;
    in_if.last_in_image  = 1'b0;
    out_if.ready         = 1'b0;
    shadow_attr          = '0;
    errors               = 0;
    cycle_count          = 0;
    cells_sent           = 0;
    bytes_checked        = 0;
    wrap_count           = 0;
    restyle_count        = 0;
    hidden_count         = 0;
    burst_left           = 0;
    steady_send          = 1'b0;
    stall_mode           = 0;
    stall_mode_left      = 0;
    hold_left            = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_full_sgr_and_cursor();
    test_column_wrap();
    test_attribute_changes();
    test_hidden_rows();
    test_home_sequence();
    test_random_images(CELL_TARGET, cells_sent + 50);

    in_if.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d cells, checked %0d bytes over %0d cycles", cells_sent,
             bytes_checked, cycle_count);
    $display("cells seen: %0d column wraps, %0d attribute changes, %0d off-screen rows",
             wrap_count, restyle_count, hidden_count);
    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d bytes never arrived", errors, expected_bytes.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
